// ===== design/depth_pixel_backprojection_assert.svh =====
// assertion macros shared by the depth pixel backprojection modules
`ifndef DEPTH_PIXEL_BACKPROJECTION_ASSERT_SVH
`define DEPTH_PIXEL_BACKPROJECTION_ASSERT_SVH

// condition holds at every edge out of reset
`define DPB_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("dpb check failed: always");

// consequent holds in the same cycle as the antecedent
`define DPB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpb check failed: same cycle");

// consequent holds in the cycle after the antecedent
`define DPB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpb check failed: next cycle");

`endif

// ===== design/dpb_pkg.sv =====
// types and constants of the depth pixel backprojection block
package dpb_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int DEPTH_W        = 16;
  localparam int COLOR_W        = 8;
  localparam int RECIP_W        = 24;
  localparam int CENTER_W       = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 24;
  localparam int POINT_W        = 32;
  localparam int QDEPTH         = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_DEPTH_SCALE = 3'd0,
    REG_CENTER_X        = 3'd1,
    REG_CENTER_Y        = 3'd2,
    REG_INV_FOCAL_X     = 3'd3,
    REG_INV_FOCAL_Y     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [RECIP_W-1:0]  inv_depth_scale;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [RECIP_W-1:0]  inv_focal_x;
    logic [RECIP_W-1:0]  inv_focal_y;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    inv_depth_scale: 24'd16777,
    center_x:        16'd5208,
    center_y:        16'd4056,
    inv_focal_x:     24'd32388,
    inv_focal_y:     24'd32326
  };

  typedef struct packed {
    logic [DEPTH_W-1:0] raw_depth;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } pix_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

// ===== design/dpb_if.sv =====
// channel interfaces: pixel input, point output and register write
interface dpb_in_if import dpb_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_row;
  logic [COORD_BITS-1:0] pixel_column;
  logic [DEPTH_W-1:0]    raw_depth;
  logic [COLOR_W-1:0]    blue_in;
  logic [COLOR_W-1:0]    green_in;
  logic [COLOR_W-1:0]    red_in;

  modport source (output valid, pixel_row, pixel_column, raw_depth, blue_in, green_in,
                  red_in, input ready);
  modport sink (input valid, pixel_row, pixel_column, raw_depth, blue_in, green_in,
                red_in, output ready);
endinterface

interface dpb_out_if import dpb_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [POINT_W-1:0] point_x;
  logic signed [POINT_W-1:0] point_y;
  logic [POINT_W-1:0]        point_z;
  logic [COLOR_W-1:0]        blue_out;
  logic [COLOR_W-1:0]        green_out;
  logic [COLOR_W-1:0]        red_out;

  modport source (output valid, point_x, point_y, point_z, blue_out, green_out, red_out,
                  input ready);
  modport sink (input valid, point_x, point_y, point_z, blue_out, green_out, red_out,
                output ready);
endinterface

interface dpb_cfg_if import dpb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/dpb_front.sv =====
// front stage: accepts pixels, drops empty depth, computes signed offsets
module dpb_front import dpb_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int OFF_BITS   = 16,
  parameter int ENTRY_W    = 2 * (OFF_BITS + 1) + $bits(pix_t)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  dpb_in_if.sink             in_px,
  input  q_stat_t            q_stat,
  output logic               push,
  output logic [ENTRY_W-1:0] entry
);

  logic               fr_valid_r, fr_valid_nxt;
  logic [ENTRY_W-1:0] fr_entry_r;
  logic               in_ready;
  logic               load;
  logic [OFF_BITS-1:0] pos_x, pos_y, cen_x, cen_y, mag_x, mag_y;
  logic                neg_x, neg_y;
  pix_t                pix;

  assign push     = fr_valid_r && !q_stat.full;
  assign in_ready = !fr_valid_r || !q_stat.full;
  assign load     = in_px.valid && in_ready;
  assign in_px.ready = in_ready;
  assign entry    = fr_entry_r;

  // position in 1/16 pixel against the principal point
  always_comb begin
    pos_x = OFF_BITS'({in_px.pixel_column, 4'd0});
    pos_y = OFF_BITS'({in_px.pixel_row, 4'd0});
    cen_x = OFF_BITS'(cfg.center_x);
    cen_y = OFF_BITS'(cfg.center_y);
    neg_x = pos_x < cen_x;
    neg_y = pos_y < cen_y;
    mag_x = neg_x ? cen_x - pos_x : pos_x - cen_x;
    mag_y = neg_y ? cen_y - pos_y : pos_y - cen_y;
    pix.raw_depth = in_px.raw_depth;
    pix.blue      = in_px.blue_in;
    pix.green     = in_px.green_in;
    pix.red       = in_px.red_in;
  end

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (load) begin
      // a zero depth item is consumed here and never queued
      fr_valid_nxt = in_px.raw_depth != '0;
    end else if (push) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fr_entry_r <= {neg_x, mag_x, neg_y, mag_y, pix};
    end
  end

endmodule

// ===== design/dpb_queue.sv =====
// small queue between the front stage and the arithmetic pipeline
module dpb_queue import dpb_pkg::*; #(
  parameter int WIDTH = 74
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output q_stat_t          q_stat
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [WIDTH-1:0] entries_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign q_stat.empty = count_r == '0;
  assign q_stat.full  = count_r == CNT_W'(QDEPTH);
  assign rd_data      = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= wr_data;
    end
  end

`include "depth_pixel_backprojection_assert.svh"

  `DPB_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(QDEPTH))
  `DPB_ASSERT_SAME(a_no_push_full, push, !q_stat.full)
  `DPB_ASSERT_SAME(a_no_pop_empty, pop, !q_stat.empty)
  `DPB_ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + 1'b1)

endmodule

// ===== design/dpb_back.sv =====
// arithmetic pipeline: depth scaling, focal scaling, offset product, saturation
module dpb_back import dpb_pkg::*; #(
  parameter int OFF_BITS = 16,
  parameter int ENTRY_W  = 2 * (OFF_BITS + 1) + $bits(pix_t)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  q_stat_t            q_stat,
  input  logic [ENTRY_W-1:0] q_entry,
  output logic               pop,
  dpb_out_if.source          out_pt
);

  localparam int PIX_W   = $bits(pix_t);
  localparam int ZF_W    = DEPTH_W + RECIP_W;
  localparam int P_W     = POINT_W + RECIP_W;
  localparam int T_W     = P_W - 16;
  localparam int PROD_W  = OFF_BITS + T_W;
  localparam int MAG_W   = PROD_W - 12;
  localparam logic [ZF_W-1:0]   Z_HALF = ZF_W'(128);
  localparam logic [P_W-1:0]    T_HALF = P_W'(32768);
  localparam logic [PROD_W-1:0] M_HALF = PROD_W'(2048);

  logic               en;
  logic [4:0]         v_r;
  logic [ENTRY_W-1:0] ent_r [4];
  logic [ZF_W-1:0]    zf_r;
  logic [ZF_W-1:0]    zf_sum;
  logic [POINT_W-1:0] z2_r, z3_r, z4_r, z5_r;
  logic [P_W-1:0]     px_r, py_r;
  logic [P_W-1:0]     px_sum, py_sum;
  logic [T_W-1:0]     tx_r, ty_r;
  logic [PROD_W-1:0]  mx_r, my_r;
  logic [PROD_W-1:0]  mx_sum, my_sum;
  logic               neg_x5_r, neg_y5_r;
  pix_t               pix5_r;
  pix_t               q_pix;
  pix_t               pix4;
  logic               out_valid_r;
  logic [POINT_W-1:0] ox_r, oy_r, oz_r;
  pix_t               opix_r;

  function automatic logic [POINT_W-1:0] sat_axis(input logic neg,
                                                  input logic [MAG_W-1:0] mag);
    logic big;
    big = |mag[MAG_W-1:POINT_W-1];
    if (neg) begin
      sat_axis = big ? {1'b1, {(POINT_W-1){1'b0}}} : POINT_W'(0) - mag[POINT_W-1:0];
    end else begin
      sat_axis = big ? {1'b0, {(POINT_W-1){1'b1}}} : mag[POINT_W-1:0];
    end
  endfunction

  // the whole pipeline moves together whenever the output register can take an item
  assign en    = !out_valid_r || out_pt.ready;
  assign pop   = en && !q_stat.empty;
  assign q_pix = pix_t'(q_entry[PIX_W-1:0]);
  assign pix4  = pix_t'(ent_r[3][PIX_W-1:0]);

  // depth times scale stays below 2^40, so z never exceeds 32 bits
  assign zf_sum = zf_r + Z_HALF;
  assign px_sum = px_r + T_HALF;
  assign py_sum = py_r + T_HALF;
  assign mx_sum = mx_r + M_HALF;
  assign my_sum = my_r + M_HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[3:0], !q_stat.empty};
      out_valid_r <= v_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: depth scaling
      zf_r     <= ZF_W'(q_pix.raw_depth) * ZF_W'(cfg.inv_depth_scale);
      ent_r[0] <= q_entry;
      // stage 2: round to Q16.16
      z2_r     <= zf_sum[ZF_W-1:8];
      ent_r[1] <= ent_r[0];
      // stage 3: z over focal length
      px_r     <= P_W'(z2_r) * P_W'(cfg.inv_focal_x);
      py_r     <= P_W'(z2_r) * P_W'(cfg.inv_focal_y);
      z3_r     <= z2_r;
      ent_r[2] <= ent_r[1];
      // stage 4: round to Q.24
      tx_r     <= px_sum[P_W-1:16];
      ty_r     <= py_sum[P_W-1:16];
      z4_r     <= z3_r;
      ent_r[3] <= ent_r[2];
      // stage 5: offset magnitude times scaled depth
      mx_r     <= PROD_W'(ent_r[3][ENTRY_W-2 -: OFF_BITS]) * PROD_W'(tx_r);
      my_r     <= PROD_W'(ent_r[3][PIX_W+OFF_BITS-1 -: OFF_BITS]) * PROD_W'(ty_r);
      neg_x5_r <= ent_r[3][ENTRY_W-1];
      neg_y5_r <= ent_r[3][PIX_W+OFF_BITS];
      pix5_r   <= pix4;
      z5_r     <= z4_r;
      // stage 6: round, apply sign, saturate
      ox_r     <= sat_axis(neg_x5_r, mx_sum[PROD_W-1:12]);
      oy_r     <= sat_axis(neg_y5_r, my_sum[PROD_W-1:12]);
      oz_r     <= z5_r;
      opix_r   <= pix5_r;
    end
  end

  assign out_pt.valid     = out_valid_r;
  assign out_pt.point_x   = ox_r;
  assign out_pt.point_y   = oy_r;
  assign out_pt.point_z   = oz_r;
  assign out_pt.blue_out  = opix_r.blue;
  assign out_pt.green_out = opix_r.green;
  assign out_pt.red_out   = opix_r.red;

`include "depth_pixel_backprojection_assert.svh"

  `DPB_ASSERT_NEXT(a_stall_holds_pipe, !en, v_r == $past(v_r))
  `DPB_ASSERT_NEXT(a_out_holds, out_valid_r && !out_pt.ready, out_valid_r && ox_r == $past(ox_r))
  `DPB_ASSERT_NEXT(a_out_from_pipe, en && v_r[4], out_valid_r)

endmodule

// ===== design/depth_pixel_backprojection.sv =====
// Pinhole back-projection of depth pixels into colored 3D points in Q16.16 metres.
// One pixel is accepted every clock while the queue has room and one point leaves every
// clock while the receiver is ready; pixels with zero depth are dropped in the front
// stage and yield no point. A kept pixel passes a registered front stage, a four-entry
// queue and a six-stage pipeline with the depth, focal and offset multipliers. The queue
// lets the front keep taking pixels while the output is held, until the queue fills.
// The user must write registers through the configuration channel only while no item is
// in flight; the block itself does not enforce this. No clearing pass is needed.
module depth_pixel_backprojection import dpb_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  dpb_in_if.sink      in_px,
  dpb_out_if.source   out_pt,
  dpb_cfg_if.sink     cfg_wr
);

  localparam int OFF_BITS = (COORD_BITS + 4 > CENTER_W) ? COORD_BITS + 4 : CENTER_W;
  localparam int ENTRY_W  = 2 * (OFF_BITS + 1) + $bits(pix_t);

  cfg_t               cfg_r, cfg_nxt;
  logic               push, pop;
  logic [ENTRY_W-1:0] fr_entry, q_entry;
  q_stat_t            q_stat;

  assign cfg_wr.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid) begin
      unique case (cfg_reg_t'(cfg_wr.index))
        REG_INV_DEPTH_SCALE: cfg_nxt.inv_depth_scale = cfg_wr.data[RECIP_W-1:0];
        REG_CENTER_X:        cfg_nxt.center_x        = cfg_wr.data[CENTER_W-1:0];
        REG_CENTER_Y:        cfg_nxt.center_y        = cfg_wr.data[CENTER_W-1:0];
        REG_INV_FOCAL_X:     cfg_nxt.inv_focal_x     = cfg_wr.data[RECIP_W-1:0];
        REG_INV_FOCAL_Y:     cfg_nxt.inv_focal_y     = cfg_wr.data[RECIP_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dpb_front #(
    .COORD_BITS (COORD_BITS),
    .OFF_BITS   (OFF_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_px  (in_px),
    .q_stat (q_stat),
    .push   (push),
    .entry  (fr_entry)
  );

  dpb_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (fr_entry),
    .pop     (pop),
    .rd_data (q_entry),
    .q_stat  (q_stat)
  );

  dpb_back #(
    .OFF_BITS (OFF_BITS),
    .ENTRY_W  (ENTRY_W)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_stat  (q_stat),
    .q_entry (q_entry),
    .pop     (pop),
    .out_pt  (out_pt)
  );

endmodule

// ===== test/depth_pixel_backprojection_tb.sv =====
// testbench for depth_pixel_backprojection: predicted points checked against the point stream
module depth_pixel_backprojection_tb;
  import dpb_pkg::*;

  localparam int COORD_BITS    = COORD_BITS_DEF;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_PIXELS  = 150;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  localparam logic [RECIP_W-1:0]  RECIP_MAX  = {RECIP_W{1'b1}};
  localparam logic [CENTER_W-1:0] CENTER_MAX = {CENTER_W{1'b1}};
  localparam logic [63:0]         Z_MAX      = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic [DEPTH_W-1:0]    depth;
    logic [COLOR_W-1:0]    blue;
    logic [COLOR_W-1:0]    green;
    logic [COLOR_W-1:0]    red;
  } pixel_t;

  typedef struct packed {
    logic signed [POINT_W-1:0] x;
    logic signed [POINT_W-1:0] y;
    logic [POINT_W-1:0]        z;
    logic [COLOR_W-1:0]        blue;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        red;
  } point_t;

  logic clk;
  logic rst_n;

  dpb_in_if #(.COORD_BITS(COORD_BITS)) in_px ();
  dpb_out_if out_pt ();
  dpb_cfg_if cfg_wr ();

  depth_pixel_backprojection #(.COORD_BITS(COORD_BITS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (in_px),
    .out_pt (out_pt),
    .cfg_wr (cfg_wr)
  );

  cfg_t   calib;
  point_t pending_points[$];
  bit     src_gapless;
  int     errors;
  int     pixels_sent;
  int     zero_depth_sent;
  int     points_checked;
  int     reg_writes;
  int     saturated_axes;
  int     cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d points outstanding", $time, cycle_count,
               pending_points.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  // one axis: offset in 1/16 pixel times z over focal length, rounded, saturated
  function automatic logic [POINT_W-1:0] project_axis(logic [COORD_BITS-1:0] coord,
                                                      logic [CENTER_W-1:0] center,
                                                      logic [63:0] z,
                                                      logic [RECIP_W-1:0] inv_focal);
    logic [63:0] pos;
    logic [63:0] cen;
    logic [63:0] off;
    logic [63:0] focal;
    logic [63:0] t;
    logic [63:0] mag;
    logic        neg;
    pos   = 64'(coord) << 4;
    cen   = 64'(center);
    focal = 64'(inv_focal);
    neg   = pos < cen;
    off   = neg ? cen - pos : pos - cen;
    t     = (z * focal + 64'd32768) >> 16;
    mag   = (off * t + 64'd2048) >> 12;
    if (neg) begin
      if (mag >= 64'h8000_0000) return 32'h8000_0000;
      return 32'(64'd0 - mag);
    end
    if (mag > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return mag[POINT_W-1:0];
  endfunction

  function automatic point_t backproject(cfg_t c, pixel_t p);
    point_t      pt;
    logic [63:0] zf;
    logic [63:0] z;
    zf = 64'(p.depth) * 64'(c.inv_depth_scale);
    z  = (zf + 64'd128) >> 8;
    if (z > Z_MAX) z = Z_MAX;
    pt.x     = project_axis(p.col, c.center_x, z, c.inv_focal_x);
    pt.y     = project_axis(p.row, c.center_y, z, c.inv_focal_y);
    pt.z     = z[POINT_W-1:0];
    pt.blue  = p.blue;
    pt.green = p.green;
    pt.red   = p.red;
    return pt;
  endfunction

  task automatic send_pixel(input pixel_t p);
    int     gap;
    point_t pt;
    gap = src_gapless ? 0 : idle_cycles();
    if (gap > 0) begin
      // junk on the payload while valid is low
      in_px.valid        <= 1'b0;
      in_px.pixel_row    <= COORD_BITS'($urandom);
      in_px.pixel_column <= COORD_BITS'($urandom);
      in_px.raw_depth    <= DEPTH_W'($urandom);
      in_px.blue_in      <= COLOR_W'($urandom);
      in_px.green_in     <= COLOR_W'($urandom);
      in_px.red_in       <= COLOR_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_px.valid        <= 1'b1;
    in_px.pixel_row    <= p.row;
    in_px.pixel_column <= p.col;
    in_px.raw_depth    <= p.depth;
    in_px.blue_in      <= p.blue;
    in_px.green_in     <= p.green;
    in_px.red_in       <= p.red;
    do @(posedge clk); while (!in_px.ready);
    pixels_sent++;
    if (p.depth == '0) begin
      zero_depth_sent++;
    end else begin
      pt = backproject(calib, p);
      if (pt.x == 32'h7FFF_FFFF || pt.x == 32'h8000_0000) saturated_axes++;
      if (pt.y == 32'h7FFF_FFFF || pt.y == 32'h8000_0000) saturated_axes++;
      pending_points = {pending_points, pt};
    end
  endtask

  task automatic send_fields(input logic [COORD_BITS-1:0] row, input logic [COORD_BITS-1:0] col,
                             input logic [DEPTH_W-1:0] depth, input logic [COLOR_W-1:0] blue,
                             input logic [COLOR_W-1:0] green, input logic [COLOR_W-1:0] red);
    pixel_t p;
    p = '{row: row, col: col, depth: depth, blue: blue, green: green, red: red};
    send_pixel(p);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= data;
    do @(posedge clk); while (!cfg_wr.ready);
    reg_writes++;
    case (idx)
      REG_INV_DEPTH_SCALE: calib.inv_depth_scale = data[RECIP_W-1:0];
      REG_CENTER_X:        calib.center_x        = data[CENTER_W-1:0];
      REG_CENTER_Y:        calib.center_y        = data[CENTER_W-1:0];
      REG_INV_FOCAL_X:     calib.inv_focal_x     = data[RECIP_W-1:0];
      REG_INV_FOCAL_Y:     calib.inv_focal_y     = data[RECIP_W-1:0];
      default: ;
    endcase
  endtask

  // input idle, all points back, pipeline flushed
  task automatic quiesce();
    in_px.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes every register; centers carry junk in the bits above their width
  task automatic load_calibration(input cfg_t c);
    quiesce();
    write_reg(REG_INV_DEPTH_SCALE, c.inv_depth_scale);
    write_reg(REG_CENTER_X, {8'($urandom), c.center_x});
    write_reg(REG_CENTER_Y, {8'($urandom), c.center_y});
    write_reg(REG_INV_FOCAL_X, c.inv_focal_x);
    write_reg(REG_INV_FOCAL_Y, c.inv_focal_y);
    cfg_wr.valid <= 1'b0;
  endtask

  function automatic logic [RECIP_W-1:0] random_recip();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 24'd1;
    if (r == 1) return RECIP_MAX;
    if (r < 6) return RECIP_W'($urandom_range(1000, 70000));
    return RECIP_W'($urandom);
  endfunction

  function automatic logic [CENTER_W-1:0] random_center();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return CENTER_MAX;
    if (r < 6) return CENTER_W'($urandom_range(2000, 9000));
    return CENTER_W'($urandom);
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    int     r;
    p.row   = COORD_BITS'($urandom);
    p.col   = COORD_BITS'($urandom);
    p.blue  = COLOR_W'($urandom);
    p.green = COLOR_W'($urandom);
    p.red   = COLOR_W'($urandom);
    if ($urandom_range(0, 19) == 0) p.row = $urandom_range(0, 1) ? '1 : '0;
    if ($urandom_range(0, 19) == 0) p.col = $urandom_range(0, 1) ? '1 : '0;
    r = $urandom_range(0, 99);
    if (r < 10)      p.depth = '0;
    else if (r < 15) p.depth = '1;
    else if (r < 20) p.depth = 16'd1;
    else if (r < 50) p.depth = DEPTH_W'($urandom_range(1, 4095));
    else             p.depth = DEPTH_W'($urandom);
    return p;
  endfunction

  task automatic check_field(input string name, input logic [POINT_W-1:0] want,
                             input logic [POINT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : point_checker
    point_t want;
    if (rst_n && out_pt.valid && out_pt.ready) begin
      if (pending_points.size() == 0) begin
        $display("%0t: point with no pixel behind it, actual x %h y %h z %h", $time,
                 out_pt.point_x, out_pt.point_y, out_pt.point_z);
        errors++;
      end else begin
        want = pending_points.pop_front();
        points_checked++;
        check_field("point_x", want.x, out_pt.point_x);
        check_field("point_y", want.y, out_pt.point_y);
        check_field("point_z", want.z, out_pt.point_z);
        check_field("blue_out", POINT_W'(want.blue), POINT_W'(out_pt.blue_out));
        check_field("green_out", POINT_W'(want.green), POINT_W'(out_pt.green_out));
        check_field("red_out", POINT_W'(want.red), POINT_W'(out_pt.red_out));
      end
    end
  end

  // receiver: random stalls between bursts of ready
  initial begin : sink_pacing
    int n;
    out_pt.ready <= 1'b0;
    @(posedge clk);
    forever begin
      n = idle_cycles();
      if (n > 0) begin
        out_pt.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_pt.ready <= 1'b1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
      repeat (n) @(posedge clk);
    end
  end

  task automatic test_default_calibration();
    src_gapless = 1'b0;
    send_fields('0, '0, '0, 8'hFF, 8'hFF, 8'hFF);          // no measurement, no point
    send_fields('0, '0, 16'd1, 8'h00, 8'h00, 8'h00);
    send_fields('1, '1, '1, 8'hFF, 8'hFF, 8'hFF);
    send_fields(12'd253, 12'd325, 16'd1000, 8'hAA, 8'h55, 8'hAA);
    send_fields(12'd254, 12'd326, 16'd1000, 8'h55, 8'hAA, 8'h55);
    send_fields('1, '0, 16'd4500, 8'h01, 8'h80, 8'hFE);
    send_fields('0, '1, '0, 8'h12, 8'h34, 8'h56);
  endtask

  task automatic test_register_limits();
    cfg_t c;
    // scale and reciprocals at the top, centers at zero: positive saturation far off center
    c = '{inv_depth_scale: RECIP_MAX, center_x: '0, center_y: '0,
          inv_focal_x: RECIP_MAX, inv_focal_y: RECIP_MAX};
    load_calibration(c);
    send_fields('1, '1, '1, 8'hFF, 8'h00, 8'hFF);
    send_fields('0, '0, 16'd1, 8'h00, 8'hFF, 8'h00);
    // centers at the top: negative saturation at the origin
    c.center_x = CENTER_MAX;
    c.center_y = CENTER_MAX;
    load_calibration(c);
    send_fields('0, '0, '1, 8'h0F, 8'hF0, 8'h3C);
    send_fields('1, '1, 16'd300, 8'hC3, 8'h5A, 8'hA5);
    // zero depth scale gives z of zero
    c = CFG_RESET;
    c.inv_depth_scale = '0;
    load_calibration(c);
    send_fields(12'd100, 12'd4000, 16'd4000, 8'h11, 8'h22, 8'h33);
    // zero focal reciprocals collapse x and y
    c = '{inv_depth_scale: 24'd1, center_x: 16'd1, center_y: CENTER_MAX,
          inv_focal_x: '0, inv_focal_y: '0};
    load_calibration(c);
    send_fields('1, '0, '1, 8'h44, 8'h55, 8'h66);
    // smallest nonzero reciprocals
    c.inv_focal_x = 24'd1;
    c.inv_focal_y = 24'd1;
    load_calibration(c);
    send_fields('1, '0, '1, 8'h77, 8'h88, 8'h99);
    // writes to spare indexes leave the calibration alone
    c = CFG_RESET;
    load_calibration(c);
    for (int k = REG_SPARE_FIRST; k <= REG_SPARE_LAST; k++) begin
      write_reg(k[CFG_IDX_W-1:0], CFG_DATA_W'($urandom));
    end
    cfg_wr.valid <= 1'b0;
    send_fields(12'd479, 12'd639, 16'd2500, 8'hDE, 8'hAD, 8'hBE);
    send_fields(12'd0, 12'd639, 16'd800, 8'hEF, 8'h01, 8'h02);
  endtask

  task automatic test_random_pixels();
    cfg_t c;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) begin
        c = CFG_RESET;
      end else begin
        c.inv_depth_scale = random_recip();
        c.center_x        = random_center();
        c.center_y        = random_center();
        c.inv_focal_x     = random_recip();
        c.inv_focal_y     = random_recip();
      end
      load_calibration(c);
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                  CFG_DATA_W'($urandom));
        cfg_wr.valid <= 1'b0;
      end
      src_gapless = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_PIXELS; i++) send_pixel(random_pixel());
    end
    src_gapless = 1'b0;
  endtask

  initial begin
    errors          = 0;
    pixels_sent     = 0;
    zero_depth_sent = 0;
    points_checked  = 0;
    reg_writes      = 0;
    saturated_axes  = 0;
    cycle_count     = 0;
    src_gapless     = 1'b0;
    calib           = CFG_RESET;
    rst_n              <= 1'b0;
    in_px.valid        <= 1'b0;
    in_px.pixel_row    <= '0;
    in_px.pixel_column <= '0;
    in_px.raw_depth    <= '0;
    in_px.blue_in      <= '0;
    in_px.green_in     <= '0;
    in_px.red_in       <= '0;
    cfg_wr.valid       <= 1'b0;
    cfg_wr.index       <= '0;
    cfg_wr.data        <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_calibration();
    test_register_limits();
    test_random_pixels();
    quiesce();

    if (pending_points.size() != 0) begin
      $display("%0t: %0d expected points never arrived", $time, pending_points.size());
      errors++;
    end
    $display("run covered %0d pixels (%0d without depth) and %0d compared points",
             pixels_sent, zero_depth_sent, points_checked);
    $display("across %0d register writes, with %0d saturated x or y coordinates",
             reg_writes, saturated_axes);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/dpb_pkg.sv
design/dpb_if.sv
design/dpb_front.sv
design/dpb_queue.sv
design/dpb_back.sv
design/depth_pixel_backprojection.sv
test/depth_pixel_backprojection_tb.sv
